/* src/apmm_pkg.sv */
`timescale 1ns / 1ps

package apmm_pkg;

  localparam int CORDIC_STEPS        = 16;
  localparam int ANGLE_FRACTION_BITS = 20;

  localparam int STEP_W  = 5;
  localparam int XY_W    = 36;
  localparam int ZW      = 32;
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 72;

  localparam int ANG_W  = 24;
  localparam int INT_W  = 32;
  localparam int RATE_W = ANGLE_FRACTION_BITS + 2;
  localparam int TILT_W = ANGLE_FRACTION_BITS + 2;
  localparam int T_W    = ANG_W + 1;
  localparam int E_W    = (ANGLE_FRACTION_BITS + 6 > 26) ? ANGLE_FRACTION_BITS + 6 : 26;
  localparam int DD_W   = 40;
  localparam int Y_W    = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [31:0] RATE_SCALE = 32'd3748066029;
  localparam logic [15:0] W_KEEP     = 16'd63570;
  localparam logic [15:0] W_ACC      = 16'd1966;
  localparam logic [15:0] W_DT       = 16'd1311;

  localparam logic [31:0] AIM_K       = 32'((64'd1 << ANGLE_FRACTION_BITS) / 15);
  localparam logic [3:0]  AIM_R       = 4'((64'd1 << ANGLE_FRACTION_BITS) % 15);
  localparam logic [12:0] RECIP15_S16 = 13'd4370;

  localparam logic signed [ZW-1:0] ATAN_Q30 [24] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_P   = 3'd0,
    CFG_ANGLE_I   = 3'd1,
    CFG_RATE_P    = 3'd2,
    CFG_INT_THR   = 3'd3,
    CFG_PULSE_MIN = 3'd4,
    CFG_PULSE_MAX = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_roll;
    logic signed [15:0] gyro_pitch;
    logic [11:0]        base_power;
    logic signed [7:0]  aim_roll_cmd;
    logic signed [7:0]  aim_pitch_cmd;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        motor_one;
    logic [11:0]        motor_two;
    logic [11:0]        motor_three;
    logic [11:0]        motor_four;
    logic signed [23:0] roll_estimate;
    logic signed [23:0] pitch_estimate;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clr_integ;
    logic neg_tilt;
  } axis_ctl_t;

  typedef struct packed {
    logic [23:0] angle_p;
    logic [23:0] angle_i;
    logic [19:0] rate_p;
  } gains_t;

endpackage

/* src/apmm_mul.sv */
`timescale 1ns / 1ps

module apmm_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 clr,
  input  logic signed [apmm_pkg::MUL_A_W-1:0]  a,
  input  logic [apmm_pkg::MUL_B_W-1:0]         b,
  output logic                                 done,
  output logic signed [apmm_pkg::PROD_W-1:0]   p
);
  import apmm_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic                     run_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [PROD_W-1:0] a_sh_r;
  logic [MUL_B_W-1:0]       b_r;
  logic signed [PROD_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CNT_W'(MUL_B_W - 1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          run_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= PROD_W'(a);
      b_r    <= b;
      if (clr) begin
        acc_r <= '0;
      end
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_sh_r;
      end
      a_sh_r <= a_sh_r <<< 1;
      b_r    <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

/* src/apmm_axis.sv */
`timescale 1ns / 1ps

module apmm_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  apmm_pkg::axis_ctl_t                 ctl,
  input  apmm_pkg::gains_t                    gains,
  input  logic signed [15:0]                  num,
  input  logic signed [15:0]                  den,
  input  logic signed [15:0]                  gyro,
  input  logic signed [7:0]                   cmd,
  output logic                                done,
  output logic signed [apmm_pkg::ANG_W-1:0]   angle,
  output logic signed [apmm_pkg::Y_W-1:0]     loop_y
);
  import apmm_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_CORDIC, A_LAUNCH, A_WAIT} astate_t;
  typedef enum logic [2:0] {
    P_RATE, P_DT, P_KEEP, P_ACC, P_AIM, P_PROP, P_INT, P_RATEP
  } pass_t;

  localparam int F = ANGLE_FRACTION_BITS;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  localparam logic signed [ZW-1:0]     TILT_HALF = ZW'(1) << (29 - F);
  localparam logic signed [PROD_W-1:0] HALF_RATE = PROD_W'(1) << (46 - F);
  localparam logic signed [PROD_W-1:0] HALF_16   = PROD_W'(1) << 15;
  localparam logic signed [PROD_W-1:0] HALF_20   = PROD_W'(1) << 19;
  localparam logic signed [PROD_W-1:0] ANG_MAX   = (PROD_W'(1) << (ANG_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] ANG_MIN   = ~ANG_MAX;
  localparam logic signed [INT_W:0]    INT_MAX   = (33'(1) << (INT_W - 1)) - 33'(1);
  localparam logic signed [INT_W:0]    INT_MIN   = ~INT_MAX;

  astate_t                   state_r;
  pass_t                     pass_r;
  logic [STEP_W-1:0]         step_r;
  logic                      done_r;
  logic signed [ANG_W-1:0]   angle_r, angle_nxt;
  logic signed [INT_W-1:0]   integ_r, integ_nxt;

  logic signed [XY_W-1:0]    x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0]      z_r, z_nxt, z_rnd;
  logic                      zero_r;
  logic signed [TILT_W-1:0]  tilt_r;
  logic [10:0]               mr_r;
  logic [6:0]                corr_r;
  logic [23:0]               corr_prod;
  logic signed [RATE_W-1:0]  rate_r;
  logic signed [T_W-1:0]     t_r;
  logic signed [E_W-1:0]     e_r, e_v, q_v, aim_v;
  logic signed [DD_W-1:0]    dd_r;
  logic signed [Y_W-1:0]     y_out_r;

  logic [7:0]                cmd_mag;
  logic signed [16:0]        den_abs;

  logic                      mul_start, mul_clr, mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p, p_rnd16, p_mag, p_sh;
  logic signed [INT_W:0]     isum;

  assign cmd_mag = cmd[7] ? 8'(-cmd) : 8'(cmd);
  assign den_abs = den[15] ? -17'(den) : 17'(den);

  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    if (y_r > 0) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + ATAN_Q30[step_r];
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - ATAN_Q30[step_r];
    end
    z_rnd = (z_nxt + TILT_HALF) >>> (30 - F);
  end

  always_comb begin
    mul_clr = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (pass_r)
      P_RATE: begin
        mul_a = MUL_A_W'(gyro);
        mul_b = RATE_SCALE;
      end
      P_DT: begin
        mul_a = MUL_A_W'(rate_r);
        mul_b = MUL_B_W'(W_DT);
      end
      P_KEEP: begin
        mul_a = MUL_A_W'(t_r);
        mul_b = MUL_B_W'(W_KEEP);
      end
      P_ACC: begin
        mul_a   = ctl.neg_tilt ? -MUL_A_W'(tilt_r) : MUL_A_W'(tilt_r);
        mul_b   = MUL_B_W'(W_ACC);
        mul_clr = 1'b0;
      end
      P_AIM: begin
        mul_a = MUL_A_W'(signed'({1'b0, cmd_mag}));
        mul_b = AIM_K;
      end
      P_PROP: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = MUL_B_W'(gains.angle_p);
      end
      P_INT: begin
        mul_a   = MUL_A_W'(integ_r);
        mul_b   = MUL_B_W'(gains.angle_i);
        mul_clr = 1'b0;
      end
      P_RATEP: begin
        mul_a = MUL_A_W'(dd_r);
        mul_b = MUL_B_W'(gains.rate_p);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_start = (state_r == A_LAUNCH);

  apmm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .clr   (mul_clr),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    p_rnd16 = (mul_p + HALF_16) >>> 16;
    if (p_rnd16 > ANG_MAX) begin
      angle_nxt = ANG_W'(ANG_MAX);
    end else if (p_rnd16 < ANG_MIN) begin
      angle_nxt = ANG_W'(ANG_MIN);
    end else begin
      angle_nxt = ANG_W'(p_rnd16);
    end
    q_v   = E_W'(mul_p) + E_W'(signed'({1'b0, corr_r}));
    aim_v = cmd[7] ? -q_v : q_v;
    e_v   = aim_v - E_W'(angle_r);
    isum  = (INT_W + 1)'(integ_r) + (INT_W + 1)'(e_v);
    if (ctl.clr_integ) begin
      integ_nxt = '0;
    end else if (isum > INT_MAX) begin
      integ_nxt = INT_W'(INT_MAX);
    end else if (isum < INT_MIN) begin
      integ_nxt = INT_W'(INT_MIN);
    end else begin
      integ_nxt = INT_W'(isum);
    end
    p_mag = mul_p[PROD_W-1] ? -mul_p : mul_p;
    p_sh  = p_mag >> (8 + F);
  end

  assign corr_prod = 24'(mr_r) * 24'(RECIP15_S16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      pass_r  <= P_RATE;
      step_r  <= '0;
      done_r  <= 1'b0;
      angle_r <= '0;
      integ_r <= '0;
    end else begin
      done_r <= (state_r == A_WAIT) && mul_done && (pass_r == P_RATEP);
      case (state_r)
        A_IDLE: begin
          if (ctl.start) begin
            state_r <= A_CORDIC;
            step_r  <= '0;
          end
        end
        A_CORDIC: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_LAST) begin
            state_r <= A_LAUNCH;
            pass_r  <= P_RATE;
          end
        end
        A_LAUNCH: begin
          state_r <= A_WAIT;
        end
        A_WAIT: begin
          if (mul_done) begin
            if (pass_r == P_ACC) begin
              angle_r <= angle_nxt;
            end
            if (pass_r == P_AIM) begin
              integ_r <= integ_nxt;
            end
            if (pass_r == P_RATEP) begin
              state_r <= A_IDLE;
            end else begin
              pass_r  <= pass_t'(pass_r + 3'd1);
              state_r <= A_LAUNCH;
            end
          end
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == A_IDLE && ctl.start) begin
      x_r    <= XY_W'(den_abs) <<< 16;
      y_r    <= XY_W'(num) <<< 16;
      z_r    <= '0;
      zero_r <= (num == 16'sd0) && (den == 16'sd0);
      mr_r   <= 11'(cmd_mag) * 11'(AIM_R) + 11'd7;
    end
    if (state_r == A_CORDIC) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      corr_r <= corr_prod[22:16];
      if (step_r == STEP_LAST) begin
        tilt_r <= zero_r ? '0 : TILT_W'(z_rnd);
      end
    end
    if (state_r == A_WAIT && mul_done) begin
      case (pass_r)
        P_RATE:  rate_r  <= RATE_W'((mul_p + HALF_RATE) >>> (47 - F));
        P_DT:    t_r     <= T_W'(angle_r) + T_W'(p_rnd16);
        P_AIM:   e_r     <= e_v;
        P_INT:   dd_r    <= DD_W'((mul_p + HALF_20) >>> 20) - DD_W'(rate_r);
        P_RATEP: y_out_r <= mul_p[PROD_W-1] ? -Y_W'(p_sh) : Y_W'(p_sh);
        default: begin
        end
      endcase
    end
  end

  assign done   = done_r;
  assign angle  = angle_r;
  assign loop_y = y_out_r;

endmodule

/* src/attitude_pi_motor_mixer.sv */
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_item_t (sensor sample, power, commands)
// out_      output     out_valid / out_stall  out_item_t (four pulses, two estimates)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data (gains and limits)
//
// Each transaction runs a CORDIC pass, then eight passes of a bit-serial multiplier,
// per axis, with both axes in step.
// The next input transaction is taken once the result sits in the output register.
// rst_n is synchronous; it clears the angle estimates and integrators and restores
// the default configuration.
// A stalled result holds the block after it finishes the following transaction.

module attitude_pi_motor_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  apmm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output apmm_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apmm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import apmm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_MIX} state_t;

  localparam int MIX_W = 34;

  state_t                 state_r;
  logic                   start_r;
  logic                   clr_r;
  logic                   out_valid_r;
  gains_t                 gains_r;
  logic [11:0]            thr_r, pmin_r, pmax_r;
  in_item_t               item_r;
  out_item_t              out_r;

  axis_ctl_t              ctl_roll, ctl_pitch;
  logic                   roll_done, pitch_done;
  logic signed [ANG_W-1:0] roll_ang, pitch_ang;
  logic signed [Y_W-1:0]  roll_y, pitch_y;
  logic signed [MIX_W-1:0] pw, yr, yp;
  logic                   accept, load_out;

  function automatic logic [11:0] clamp_pulse(input logic signed [MIX_W-1:0] v,
                                               input logic [11:0] lo,
                                               input logic [11:0] hi);
    logic signed [MIX_W-1:0] lo_s;
    logic signed [MIX_W-1:0] hi_s;
    lo_s = MIX_W'(signed'({1'b0, lo}));
    hi_s = MIX_W'(signed'({1'b0, hi}));
    if (v < lo_s) begin
      return lo;
    end else if (v > hi_s) begin
      return hi;
    end
    return v[11:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state_r == S_MIX) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ctl_roll  = '{start: start_r, clr_integ: clr_r, neg_tilt: 1'b0};
  assign ctl_pitch = '{start: start_r, clr_integ: clr_r, neg_tilt: 1'b1};

  apmm_axis u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_roll),
    .gains  (gains_r),
    .num    (item_r.accel_y),
    .den    (item_r.accel_z),
    .gyro   (item_r.gyro_roll),
    .cmd    (item_r.aim_roll_cmd),
    .done   (roll_done),
    .angle  (roll_ang),
    .loop_y (roll_y)
  );

  apmm_axis u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_pitch),
    .gains  (gains_r),
    .num    (item_r.accel_x),
    .den    (item_r.accel_z),
    .gyro   (item_r.gyro_pitch),
    .cmd    (item_r.aim_pitch_cmd),
    .done   (pitch_done),
    .angle  (pitch_ang),
    .loop_y (pitch_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.angle_p <= 24'd10486;
      gains_r.angle_i <= 24'd1049;
      gains_r.rate_p  <= 20'd153600;
      thr_r           <= 12'd1300;
      pmin_r          <= 12'd1000;
      pmax_r          <= 12'd1800;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ANGLE_P:   gains_r.angle_p <= cfg_data;
        CFG_ANGLE_I:   gains_r.angle_i <= cfg_data;
        CFG_RATE_P:    gains_r.rate_p  <= cfg_data[19:0];
        CFG_INT_THR:   thr_r           <= cfg_data[11:0];
        CFG_PULSE_MIN: pmin_r          <= cfg_data[11:0];
        CFG_PULSE_MAX: pmax_r          <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (roll_done) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign pw = MIX_W'(signed'({1'b0, item_r.base_power}));
  assign yr = MIX_W'(roll_y);
  assign yp = MIX_W'(pitch_y);

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      clr_r  <= (in_data.base_power < thr_r);
    end
    if (load_out) begin
      out_r.motor_one      <= clamp_pulse(pw - yr - yp, pmin_r, pmax_r);
      out_r.motor_two      <= clamp_pulse(pw + yr - yp, pmin_r, pmax_r);
      out_r.motor_three    <= clamp_pulse(pw + yr + yp, pmin_r, pmax_r);
      out_r.motor_four     <= clamp_pulse(pw - yr + yp, pmin_r, pmax_r);
      out_r.roll_estimate  <= roll_ang;
      out_r.pitch_estimate <= pitch_ang;
    end
  end

`ifndef SYNTH
  a_axes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    roll_done == pitch_done)
    else $error("roll and pitch axes finished on different cycles");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    roll_done |-> state_r == S_RUN)
    else $error("axis finished outside of a running transaction");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RUN) && start_r)
    else $error("accepted transaction did not start the axes");
`endif

endmodule
